FILE: rtl/sedg_pkg.sv
// Package with shared constants, codes and controller/datapath types of the error dedup gate.
package sedg_pkg;

	localparam int DEF_NUM_SCOPES = 8;
	localparam int DEF_CAPACITY   = 8;

	localparam int GEN_W    = 64;
	localparam int CODE_W   = 6;
	localparam int INDEX_W  = 4;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 64;

	localparam logic [1:0] REQ_BEGIN  = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_REPORT = 2'd2;

	// Register select is address bit 3 (registers sit at byte offsets 0 and 8).
	localparam logic REG_KNOWN_MASK = 1'b0;
	localparam logic REG_UNEXPECTED = 1'b1;

	localparam logic [APB_DW-1:0] KNOWN_MASK_RESET = '1;
	localparam logic [CODE_W-1:0] UNEXPECTED_RESET = 6'd63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FETCH,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic begin_apply;
		logic cancel_apply;
		logic scan_start;
		logic scan_step;
		logic ring_write;
		logic res_we;
		logic res_val;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic       in_range;
		logic [1:0] req_type;
		logic       initialized;
		logic       active;
		logic       gen_eq;
		logic       gen_gt;
		logic       count_zero;
		logic       hit;
		logic       last;
		logic       out_free;
	} dp_status_t;

endpackage

FILE: rtl/sedg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sedg_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/sedg_regs.sv
// APB-style configuration registers: known-code mask and substitute code.
module sedg_regs import sedg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [APB_DW-1:0] known_code_mask,
	output logic [CODE_W-1:0] unexpected_code
);

	logic [APB_DW-1:0] mask_q;
	logic [CODE_W-1:0] unexp_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= KNOWN_MASK_RESET;
			unexp_q <= UNEXPECTED_RESET;
		end else if (wr_en) begin
			case (paddr[3])
				REG_KNOWN_MASK: mask_q  <= pwdata;
				REG_UNEXPECTED: unexp_q <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_KNOWN_MASK: prdata = mask_q;
			REG_UNEXPECTED: prdata = {{(APB_DW-CODE_W){1'b0}}, unexp_q};
			default:        prdata = '0;
		endcase
	end

	assign known_code_mask = mask_q;
	assign unexpected_code = unexp_q;

endmodule

FILE: rtl/sedg_ctrl.sv
// Controller state machine that sequences lookup, ring scan, ring write and result hand-off.
module sedg_ctrl import sedg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_FINISH;
				if (status.in_range && status.req_type == REQ_REPORT &&
				    status.active && status.gen_eq) begin
					state_d = status.count_zero ? ST_WRITE : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_SCAN;
			ST_SCAN: begin
				if (status.hit) state_d = ST_FINISH;
				else if (status.last) state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EVAL: begin
				cmd.res_we = 1'b1;
				if (status.in_range) begin
					case (status.req_type)
						REQ_BEGIN: begin
							if (!status.initialized || status.gen_gt) begin
								cmd.begin_apply = 1'b1;
								cmd.res_val     = 1'b1;
							end else begin
								cmd.res_val = status.gen_eq & status.active;
							end
						end
						REQ_CANCEL: cmd.cancel_apply = status.gen_eq;
						REQ_REPORT: begin
							cmd.scan_start = status.active & status.gen_eq &
							                 !status.count_zero;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: cmd.scan_step = 1'b1;
			ST_SCAN: begin
				if (status.hit) begin
					cmd.res_we = 1'b1;
				end else if (!status.last) begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_WRITE: begin
				cmd.ring_write = 1'b1;
				cmd.res_we     = 1'b1;
				cmd.res_val    = 1'b1;
			end
			ST_FINISH: cmd.out_load = status.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/sedg_dp.sv
// Datapath: request capture, per-scope state, code ring memory and output register.
module sedg_dp import sedg_pkg::*; #(
	parameter int NUM_SCOPES = DEF_NUM_SCOPES,
	parameter int CAPACITY   = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic [1:0]         req_type,
	input  logic [INDEX_W-1:0] operation_index,
	input  logic [GEN_W-1:0]   generation,
	input  logic [CODE_W-1:0]  error_code,
	input  logic [APB_DW-1:0]  known_code_mask,
	input  logic [CODE_W-1:0]  unexpected_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted
);

	localparam int SW    = (NUM_SCOPES > 1) ? $clog2(NUM_SCOPES) : 1;
	localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int DEPTH = NUM_SCOPES * CAPACITY;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = AW + 1;

	logic [1:0]        req_type_q;
	logic [SW-1:0]     idx_q;
	logic [GEN_W-1:0]  gen_q;
	logic [CODE_W-1:0] code_q;
	logic              in_range_q;

	logic              scope_init_q   [NUM_SCOPES];
	logic              scope_active_q [NUM_SCOPES];
	logic [GEN_W-1:0]  scope_gen_q    [NUM_SCOPES];
	logic [CW-1:0]     scope_count_q  [NUM_SCOPES];
	logic [PW-1:0]     scope_next_q   [NUM_SCOPES];

	logic [CW-1:0]     scan_q;
	logic              res_q;
	logic              out_valid_q;
	logic              accepted_q;

	logic [CODE_W-1:0] norm_code;
	logic [XW-1:0]     base_addr;
	logic [XW-1:0]     rd_addr;
	logic [XW-1:0]     wr_addr;
	logic [CODE_W-1:0] ring_rdata;
	logic [CW-1:0]     cur_count;
	logic [PW-1:0]     cur_next;

	assign norm_code = known_code_mask[error_code] ? error_code : unexpected_code;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			idx_q      <= operation_index[SW-1:0];
			gen_q      <= generation;
			code_q     <= norm_code;
			in_range_q <= ({1'b0, operation_index} < (INDEX_W + 1)'(NUM_SCOPES));
		end
	end

	assign cur_count = scope_count_q[idx_q];
	assign cur_next  = scope_next_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SCOPES; s++) begin
				scope_init_q[s]   <= 1'b0;
				scope_active_q[s] <= 1'b0;
				scope_gen_q[s]    <= '0;
				scope_count_q[s]  <= '0;
				scope_next_q[s]   <= '0;
			end
		end else begin
			if (cmd.begin_apply) begin
				scope_init_q[idx_q]   <= 1'b1;
				scope_active_q[idx_q] <= 1'b1;
				scope_gen_q[idx_q]    <= gen_q;
				scope_count_q[idx_q]  <= '0;
				scope_next_q[idx_q]   <= '0;
			end
			if (cmd.cancel_apply) begin
				scope_active_q[idx_q] <= 1'b0;
			end
			if (cmd.ring_write) begin
				scope_next_q[idx_q] <= (cur_next == PW'(CAPACITY - 1)) ? '0 : cur_next + 1'b1;
				if (cur_count != CW'(CAPACITY)) begin
					scope_count_q[idx_q] <= cur_count + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan_start) begin
			scan_q <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	assign base_addr = XW'(idx_q) * XW'(CAPACITY);
	assign rd_addr   = base_addr + XW'(scan_q);
	assign wr_addr   = base_addr + XW'(cur_next);

	sedg_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ring_write),
		.waddr (wr_addr[AW-1:0]),
		.wdata (code_q),
		.raddr (rd_addr[AW-1:0]),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			res_q <= cmd.res_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			accepted_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;

	always_comb begin
		status             = '0;
		status.in_range    = in_range_q;
		status.req_type    = req_type_q;
		status.initialized = scope_init_q[idx_q];
		status.active      = scope_active_q[idx_q];
		status.gen_eq      = (gen_q == scope_gen_q[idx_q]);
		status.gen_gt      = (gen_q > scope_gen_q[idx_q]);
		status.count_zero  = (cur_count == '0);
		status.hit         = (ring_rdata == code_q);
		status.last        = (scan_q == cur_count);
		status.out_free    = !out_valid_q || out_ready;
	end

endmodule

FILE: rtl/scoped_error_dedup_gate.sv
// Top level of the scoped error dedup gate.
//
// Requests arrive on the in_valid/in_ready channel as req_type, operation_index,
// generation and error_code; each transaction yields exactly one result, the
// accepted bit, on the out_valid/out_ready channel. The known-code mask and the
// substitute code are written through the APB-style port; the user must write them
// only while the block is idle, which the block does not enforce. One request is
// processed at a time. Begin, cancel, an out-of-range scope and a report that fails
// the generation check go from the evaluate state straight to the finish state, and
// a report into an empty ring passes the ring write first. Any other report goes
// through a fetch state and then reads the ring of its scope one entry a cycle
// through the single read port of the code memory; it finishes when the code is
// found, or writes the code into the ring when none of the n stored entries (at
// most CAPACITY) holds it. in_ready rises at the edge that loads the result.
// The output register holds a finished result while the receiver stalls, and the
// next request is accepted meanwhile; its result waits until that one is taken.
// Reset clears all scope flags, generations, counts and pointers and restores the
// mask to all ones and the substitute code to 63; the code memory needs no clearing.
module scoped_error_dedup_gate import sedg_pkg::*; #(
	parameter int NUM_SCOPES = DEF_NUM_SCOPES,
	parameter int CAPACITY   = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [INDEX_W-1:0] operation_index,
	input  logic [GEN_W-1:0]   generation,
	input  logic [CODE_W-1:0]  error_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	dp_cmd_t           cmd;
	dp_status_t        status;
	logic [APB_DW-1:0] known_code_mask;
	logic [CODE_W-1:0] unexpected_code;

	sedg_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.known_code_mask (known_code_mask),
		.unexpected_code (unexpected_code)
	);

	sedg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sedg_dp #(
		.NUM_SCOPES (NUM_SCOPES),
		.CAPACITY   (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.req_type        (req_type),
		.operation_index (operation_index),
		.generation      (generation),
		.error_code      (error_code),
		.known_code_mask (known_code_mask),
		.unexpected_code (unexpected_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted)
	);

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a request is still in progress");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.begin_apply, cmd.cancel_apply, cmd.ring_write, cmd.scan_start}))
		else $error("more than one scope update in one cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded over an untaken result");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_write |=> !out_valid || $past(out_valid))
		else $error("ring write bypassed the finish step");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the scoped error dedup gate: directed table, then randomized phases.
`timescale 1ns / 100ps

module testbench import sedg_pkg::*; ();

	localparam int NSC = DEF_NUM_SCOPES;
	localparam int CAP = DEF_CAPACITY;
	localparam int ITEMS_PER_PHASE = 215;
	localparam int NUM_PHASES = 6;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [GEN_W-1:0] GMAX = {GEN_W{1'b1}};
	localparam logic [APB_AW-1:0] ADDR_MASK  = {REG_KNOWN_MASK, 3'b000};
	localparam logic [APB_AW-1:0] ADDR_UNEXP = {REG_UNEXPECTED, 3'b000};
	localparam logic PINNED = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct packed {
		logic [1:0]         rtype;
		logic [INDEX_W-1:0] idx;
		logic [GEN_W-1:0]   gen;
		logic [CODE_W-1:0]  code;
		logic               pinned;
		logic               pinned_val;
	} req_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = REQ_BEGIN;
	logic [INDEX_W-1:0] operation_index = '0;
	logic [GEN_W-1:0]   generation = '0;
	logic [CODE_W-1:0]  error_code = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               accepted;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	scoped_error_dedup_gate #(
		.NUM_SCOPES(NSC),
		.CAPACITY  (CAP)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.operation_index(operation_index),
		.generation     (generation),
		.error_code     (error_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Scope state mirrored by the predictor.
	logic              sc_init [NSC];
	logic              sc_act  [NSC];
	logic [GEN_W-1:0]  sc_gen  [NSC];
	int unsigned       sc_cnt  [NSC];
	int unsigned       sc_next [NSC];
	logic [CODE_W-1:0] sc_ring [NSC][CAP];
	logic [APB_DW-1:0] mask_m;
	logic [CODE_W-1:0] unexp_m;

	req_t req_q[$];
	logic accept_exp_q[$];
	int   send_idle = 0;
	int   recv_idle = 0;
	int   mismatch_cnt = 0;
	int   stall_cycles = 0;
	req_t cur_req;
	logic cur_pred;
	logic exp_bit;

	task automatic gate_reset_model();
		for (int s = 0; s < NSC; s++) begin
			sc_init[s] = 1'b0;
			sc_act[s]  = 1'b0;
			sc_gen[s]  = '0;
			sc_cnt[s]  = 0;
			sc_next[s] = 0;
			for (int i = 0; i < CAP; i++)
				sc_ring[s][i] = '0;
		end
		mask_m  = KNOWN_MASK_RESET;
		unexp_m = UNEXPECTED_RESET;
	endtask

	function automatic logic dedup_predict(req_t r);
		logic [CODE_W-1:0] code;
		logic hit;
		int s;
		hit = 1'b0;
		s = int'(r.idx);
		if (r.idx >= NSC)
			return 1'b0;
		case (r.rtype)
			REQ_BEGIN: begin
				if (sc_init[s] && r.gen <= sc_gen[s])
					return (r.gen == sc_gen[s]) && sc_act[s];
				sc_init[s] = 1'b1;
				sc_act[s]  = 1'b1;
				sc_gen[s]  = r.gen;
				sc_cnt[s]  = 0;
				sc_next[s] = 0;
				return 1'b1;
			end
			REQ_CANCEL: begin
				if (sc_gen[s] == r.gen)
					sc_act[s] = 1'b0;
				return 1'b0;
			end
			REQ_REPORT: begin
				if (!sc_act[s] || r.gen != sc_gen[s])
					return 1'b0;
				code = mask_m[r.code] ? r.code : unexp_m;
				for (int i = 0; i < sc_cnt[s]; i++)
					if (sc_ring[s][i] == code)
						hit = 1'b1;
				if (hit)
					return 1'b0;
				sc_ring[s][sc_next[s]] = code;
				sc_next[s] = (sc_next[s] + 1 == CAP) ? 0 : sc_next[s] + 1;
				if (sc_cnt[s] < CAP)
					sc_cnt[s]++;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic req_t draw_request();
		req_t r;
		int unsigned roll;
		logic [GEN_W-1:0] base;
		r.pinned = PREDICTED;
		r.pinned_val = 1'b0;
		roll = $urandom_range(99);
		r.rtype = (roll < 22) ? REQ_BEGIN : (roll < 32) ? REQ_CANCEL :
			(roll < 95) ? REQ_REPORT : REQ_UNUSED;
		r.idx = INDEX_W'(($urandom_range(99) < 90) ? $urandom_range(NSC - 1) :
			$urandom_range(15, NSC));
		base = (r.idx < NSC) ? sc_gen[r.idx] : {$urandom, $urandom};
		roll = $urandom_range(99);
		if (r.rtype == REQ_BEGIN)
			r.gen = (roll < 45) ? base : (roll < 80) ? base + 1 : (roll < 88) ? base - 1 :
				(roll < 95) ? {$urandom, $urandom} : GEN_W'($urandom_range(3));
		else
			r.gen = (roll < 75) ? base : (roll < 83) ? base + 1 : (roll < 90) ? base - 1 :
				(roll < 96) ? {$urandom, $urandom} : GEN_W'($urandom_range(3));
		r.code = CODE_W'(($urandom_range(1) != 0) ? $urandom_range(11) : $urandom_range(63));
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] expv, logic [63:0] actv);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("ERROR %s: expected %0h, actual %0h at %0t", what, expv, actv, $realtime);
	endtask

	// Request driver; the prediction is made when the transaction is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				cur_req = req_q.pop_front();
				cur_pred = dedup_predict(cur_req);
				accept_exp_q.push_back(cur_req.pinned ? cur_req.pinned_val : cur_pred);
			end
			if (!in_valid || in_ready) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_valid        <= 1'b1;
					req_type        <= req_q[0].rtype;
					operation_index <= req_q[0].idx;
					generation      <= req_q[0].gen;
					error_code      <= req_q[0].code;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (accept_exp_q.size() == 0) begin
				flag_mismatch("result with no request pending", 'x, 64'(accepted));
			end else begin
				exp_bit = accept_exp_q.pop_front();
				if (accepted !== exp_bit)
					flag_mismatch("accepted", 64'(exp_bit), 64'(accepted));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_request(req_t r);
		while (req_q.size() >= 2)
			@(negedge clk);
		req_q.push_back(r);
	endtask

	task automatic drain();
		while (req_q.size() != 0 || accept_exp_q.size() != 0)
			@(negedge clk);
	endtask

	// Writes one register, updates the predictor and reads the value back.
	task automatic set_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
		logic [APB_DW-1:0] keep;
		logic [APB_DW-1:0] rd;
		keep = (addr == ADDR_MASK) ? '1 : APB_DW'({CODE_W{1'b1}});
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_MASK)
			mask_m = data;
		else
			unexp_m = data[CODE_W-1:0];
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((rd & keep) !== (data & keep))
			flag_mismatch("register read back", data & keep, rd & keep);
	endtask

	initial begin
		req_t dir_tab[$];
		logic [APB_DW-1:0] m;
		logic [CODE_W-1:0] u;
		gate_reset_model();
		dir_tab = '{
			'{REQ_REPORT, 4'd0,  64'd0,    6'd0,  PINNED,    1'b0},
			'{REQ_CANCEL, 4'd0,  64'd0,    6'd0,  PINNED,    1'b0},
			'{REQ_BEGIN,  4'd15, GMAX,     6'd63, PINNED,    1'b0},
			'{REQ_REPORT, 4'd8,  64'd0,    6'd0,  PINNED,    1'b0},
			'{REQ_UNUSED, 4'd0,  64'd0,    6'd0,  PINNED,    1'b0},
			'{REQ_BEGIN,  4'd0,  64'd0,    6'd0,  PINNED,    1'b1},
			'{REQ_BEGIN,  4'd0,  64'd0,    6'd0,  PINNED,    1'b1},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd0,  PINNED,    1'b1},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd0,  PINNED,    1'b0},
			'{REQ_REPORT, 4'd0,  64'd1,    6'd5,  PINNED,    1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd63, PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd1,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd2,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd3,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd4,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd5,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd6,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd0,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd7,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd0,  64'd0,    6'd0,  PREDICTED, 1'b0},
			'{REQ_BEGIN,  4'd7,  GMAX,     6'd0,  PINNED,    1'b1},
			'{REQ_BEGIN,  4'd7,  GMAX - 1, 6'd0,  PREDICTED, 1'b0},
			'{REQ_CANCEL, 4'd7,  GMAX,     6'd0,  PINNED,    1'b0},
			'{REQ_BEGIN,  4'd7,  GMAX,     6'd0,  PREDICTED, 1'b0},
			'{REQ_REPORT, 4'd7,  GMAX,     6'd42, PREDICTED, 1'b0}
		};
		send_idle = 28;
		recv_idle = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[i])
			send_request(dir_tab[i]);
		drain();
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin m = '1; u = 6'd63; end
				1: begin m = '0; u = 6'd0; end
				2: begin m = {$urandom, $urandom}; u = CODE_W'($urandom_range(63)); end
				3: begin m = {$urandom, $urandom}; u = 6'd63; end
				4: begin m = {$urandom, $urandom} & {$urandom, $urandom}; u = 6'd0; end
				default: begin
					m = ~(64'd1 << $urandom_range(63));
					u = CODE_W'($urandom_range(63));
				end
			endcase
			set_reg(ADDR_MASK, m);
			set_reg(ADDR_UNEXP, APB_DW'(u));
			send_idle = (p < 2) ? 28 : (p < 4) ? 50 : 0;
			recv_idle = (p < 2) ? 50 : (p < 4) ? 28 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_request(draw_request());
			drain();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
